### hdl/sfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfb_pkg;

    localparam int unsigned LIMIT_BITS = 16;
    localparam int unsigned CFG_BITS   = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd3;

    localparam logic [7:0]  RST_START_BYTE  = 8'd2;
    localparam logic [7:0]  RST_END_BYTE    = 8'd3;
    localparam logic [7:0]  RST_ESCAPE_BYTE = 8'd27;
    localparam logic [15:0] RST_LIMIT       = 16'd0;

    localparam logic [8:0] SUM_MOD = 9'h0ff;

    localparam int unsigned STEP_W     = 7;
    localparam int unsigned STEP_START = 0;
    localparam int unsigned STEP_TYPE  = 1;
    localparam int unsigned STEP_ESC   = 2;
    localparam int unsigned STEP_DATA  = 3;
    localparam int unsigned STEP_CKESC = 4;
    localparam int unsigned STEP_CKS   = 5;
    localparam int unsigned STEP_END   = 6;

    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic [7:0] frame_type;
        logic       first_item;
        logic       last_item;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } t_result;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [7:0]  escape_byte;
        logic [15:0] payload_limit;
    } t_cfg;

    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [7:0]        frame_type;
        logic [7:0]        data_byte;
        logic [7:0]        checksum;
    } t_cmd;

    function automatic logic is_special(input logic [7:0] b, input t_cfg cfg);
        is_special = (b == cfg.start_byte) || (b == cfg.end_byte) || (b == cfg.escape_byte);
    endfunction

endpackage

`default_nettype wire

### hdl/stuffed_frame_builder.sv
// Byte-stuffing framer: start byte, type byte, escaped payload, escaped
// mod-255 checksum, end byte.
// Input queue side: present an item on i_item and raise push; it transfers
// at a clock edge where push is high and full is low. Output queue side: the
// oldest result sits on o_result while empty is low; it transfers at an edge
// where pop is high and empty is low. run_last marks the final byte an item
// produced; items that produce nothing are taken and vanish.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data (0 start, 1 end, 2 escape,
// 3 payload limit); the user must write only while the block is idle; the block does not enforce it.
// Path: a taken item enters the command queue, and the sequencer loads its
// bytes one by one into the output register. Throughput: one byte per cycle
// unless the receiver stalls; an item yields one to seven result bytes. A
// 4-entry command queue between the classifier and the sequencer keeps input
// taking items while the sequencer works through longer runs.
// A stalled receiver holds the output register; the queue fills and full
// rises. Synchronous reset clears frame state, queue and the output valid
// flag (not the output data) and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_builder (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sfb_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  wire sfb_pkg::t_item            i_item,
    input  wire logic                      push,
    output logic                           full,
    output sfb_pkg::t_result               o_result,
    output logic                           empty,
    input  wire logic                      pop
);
    import sfb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_empty;
    logic accept;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_BYTE:    n_cfg.start_byte    = i_cfg_data[7:0];
                CFG_END_BYTE:      n_cfg.end_byte      = i_cfg_data[7:0];
                CFG_ESCAPE_BYTE:   n_cfg.escape_byte   = i_cfg_data[7:0];
                CFG_PAYLOAD_LIMIT: n_cfg.payload_limit = i_cfg_data[15:0];
                default:           n_cfg = r_cfg;
            endcase
        end
        full   = cmd_full;
        accept = push && !cmd_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= RST_START_BYTE;
            r_cfg.end_byte      <= RST_END_BYTE;
            r_cfg.escape_byte   <= RST_ESCAPE_BYTE;
            r_cfg.payload_limit <= RST_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (i_item),
        .i_accept   (accept),
        .o_cmd      (front_cmd),
        .o_cmd_push (cmd_push)
    );

    sfb_cmd_fifo u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_push),
        .i_wr_cmd (front_cmd),
        .o_full   (cmd_full),
        .i_rd     (cmd_pop),
        .o_rd_cmd (head_cmd),
        .o_empty  (cmd_empty)
    );

    sfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

`default_nettype wire

### hdl/sfb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfb_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sfb_pkg::t_cfg  i_cfg,
    input  wire sfb_pkg::t_item i_item,
    input  wire logic           i_accept,
    output sfb_pkg::t_cmd       o_cmd,
    output logic                o_cmd_push
);
    import sfb_pkg::*;

    logic [7:0]            r_sum;
    logic [LIMIT_BITS-1:0] r_count;
    logic                  r_trunc;
    logic [7:0]            n_sum;
    logic [LIMIT_BITS-1:0] n_count;
    logic                  n_trunc;

    logic [7:0]            base_sum;
    logic [LIMIT_BITS-1:0] base_count;
    logic                  base_trunc;
    logic [8:0]            sum_raw;
    logic [7:0]            sum_upd;
    logic [LIMIT_BITS-1:0] lim;
    logic                  unlimited;
    logic [LIMIT_BITS:0]   cnt_p1;
    logic [LIMIT_BITS:0]   cnt_p2;
    logic [LIMIT_BITS-1:0] cnt_p1_sat;
    logic [LIMIT_BITS-1:0] cnt_p2_sat;
    logic                  emit_plain;
    logic                  emit_esc;
    logic                  trunc_upd;
    logic [LIMIT_BITS-1:0] count_upd;

    always_comb begin
        base_sum   = i_item.first_item ? 8'd0 : r_sum;
        base_count = i_item.first_item ? '0 : r_count;
        base_trunc = i_item.first_item ? 1'b0 : r_trunc;

        sum_raw = {1'b0, base_sum} + {1'b0, i_item.data_byte};
        if (sum_raw >= SUM_MOD) begin
            sum_raw = sum_raw - SUM_MOD;
        end
        sum_upd = i_item.has_byte ? sum_raw[7:0] : base_sum;

        lim       = LIMIT_BITS'(i_cfg.payload_limit);
        unlimited = (lim == '0);
        cnt_p1    = {1'b0, base_count} + (LIMIT_BITS + 1)'(1);
        cnt_p2    = {1'b0, base_count} + (LIMIT_BITS + 1)'(2);
        cnt_p1_sat = cnt_p1[LIMIT_BITS] ? '1 : cnt_p1[LIMIT_BITS-1:0];
        cnt_p2_sat = cnt_p2[LIMIT_BITS] ? '1 : cnt_p2[LIMIT_BITS-1:0];

        emit_plain = 1'b0;
        emit_esc   = 1'b0;
        trunc_upd  = base_trunc;
        count_upd  = base_count;
        if (i_item.has_byte && !base_trunc) begin
            if (!unlimited && (base_count >= lim)) begin
                trunc_upd = 1'b1;
            end else if (is_special(i_item.data_byte, i_cfg)) begin
                if (unlimited || (cnt_p1 < {1'b0, lim})) begin
                    emit_esc  = 1'b1;
                    count_upd = cnt_p2_sat;
                end else begin
                    trunc_upd = 1'b1;
                end
            end else begin
                emit_plain = 1'b1;
                count_upd  = cnt_p1_sat;
            end
        end

        o_cmd.frame_type = i_item.frame_type;
        o_cmd.data_byte  = i_item.data_byte;
        o_cmd.checksum   = sum_upd;
        o_cmd.steps      = '0;
        o_cmd.steps[STEP_START] = i_item.first_item;
        o_cmd.steps[STEP_TYPE]  = i_item.first_item;
        o_cmd.steps[STEP_ESC]   = emit_esc;
        o_cmd.steps[STEP_DATA]  = emit_esc || emit_plain;
        o_cmd.steps[STEP_CKESC] = i_item.last_item && is_special(sum_upd, i_cfg);
        o_cmd.steps[STEP_CKS]   = i_item.last_item;
        o_cmd.steps[STEP_END]   = i_item.last_item;

        o_cmd_push = i_accept && (o_cmd.steps != '0);

        if (i_item.last_item) begin
            n_sum   = 8'd0;
            n_count = '0;
            n_trunc = 1'b0;
        end else begin
            n_sum   = sum_upd;
            n_count = count_upd;
            n_trunc = trunc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= 8'd0;
            r_count <= '0;
            r_trunc <= 1'b0;
        end else if (i_accept) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_trunc <= n_trunc;
        end
    end

endmodule

`default_nettype wire

### hdl/sfb_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sfb_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire sfb_pkg::t_cmd i_wr_cmd,
    output logic               o_full,
    input  wire logic          i_rd,
    output sfb_pkg::t_cmd      o_rd_cmd,
    output logic               o_empty
);
    import sfb_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    logic [CMD_PTR_W-1:0] n_wr_ptr;
    logic [CMD_PTR_W-1:0] n_rd_ptr;
    logic [CMD_PTR_W:0]   n_count;

    always_comb begin
        o_full   = (r_count == (CMD_PTR_W + 1)'(CMD_DEPTH));
        o_empty  = (r_count == '0);
        o_rd_cmd = r_mem[r_rd_ptr];
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = r_wr_ptr + CMD_PTR_W'(1);
        end
        if (i_rd) begin
            n_rd_ptr = r_rd_ptr + CMD_PTR_W'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + (CMD_PTR_W + 1)'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - (CMD_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### hdl/sfb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfb_pkg::t_cfg i_cfg,
    input  wire sfb_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    output sfb_pkg::t_result   o_result,
    output logic               o_empty,
    input  wire logic          i_pop
);
    import sfb_pkg::*;

    logic [STEP_W-1:0] r_done;
    logic              r_ovld;
    t_result           r_out;
    logic [STEP_W-1:0] n_done;
    logic              n_ovld;
    t_result           n_out;

    logic [STEP_W-1:0] rem;
    logic [STEP_W-1:0] sel;
    logic              last_step;
    logic              advance;
    logic              load;
    logic [7:0]        sel_byte;

    always_comb begin
        rem       = i_cmd.steps & ~r_done;
        sel       = rem & (~rem + STEP_W'(1));
        last_step = ((rem & ~sel) == '0);
        advance   = !r_ovld || i_pop;
        load      = advance && !i_cmd_empty;
        o_cmd_pop = load && last_step;

        if (sel[STEP_START]) begin
            sel_byte = i_cfg.start_byte;
        end else if (sel[STEP_TYPE]) begin
            sel_byte = i_cmd.frame_type;
        end else if (sel[STEP_ESC] || sel[STEP_CKESC]) begin
            sel_byte = i_cfg.escape_byte;
        end else if (sel[STEP_DATA]) begin
            sel_byte = i_cmd.data_byte;
        end else if (sel[STEP_CKS]) begin
            sel_byte = i_cmd.checksum;
        end else begin
            sel_byte = i_cfg.end_byte;
        end

        n_done = r_done;
        n_ovld = r_ovld;
        n_out  = r_out;
        if (load) begin
            n_ovld          = 1'b1;
            n_out.out_byte  = sel_byte;
            n_out.frame_end = sel[STEP_END];
            n_out.run_last  = last_step;
            n_done          = last_step ? '0 : (r_done | sel);
        end else if (i_pop) begin
            n_ovld = 1'b0;
        end

        o_result = r_out;
        o_empty  = !r_ovld;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_done <= n_done;
            r_ovld <= n_ovld;
        end
    end

endmodule

`default_nettype wire
